// ===== hdl/bsfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsfd_pkg;

    localparam int unsigned FRAME_LEN  = 58;
    localparam int unsigned ADDR_W     = 6;
    localparam int unsigned VALUE_W    = 25;
    localparam int unsigned FIELD_ID_W = 5;

    localparam logic [ADDR_W-1:0]     SUM_POS    = 6'd57;
    localparam logic [FIELD_ID_W-1:0] LAST_FIELD = 5'd19;

    localparam logic [7:0] PREFIX_ZERO = 8'h58;  // 'X'
    localparam logic [7:0] PREFIX_NEG  = 8'h2D;  // '-'
    localparam logic [6:0] FLAG_MASK   = 7'h7F;

    // temp = raw*219 + floor((raw*392 + 500) / 1000) - 232*256
    localparam logic [23:0]        TEMP_MUL_INT  = 24'd219;
    localparam logic [VALUE_W-1:0] TEMP_MUL_FRAC = 25'd392;
    localparam logic [VALUE_W-1:0] TEMP_ROUND    = 25'd500;
    localparam logic [10:0]        TEMP_DIV      = 11'd1000;
    localparam logic [VALUE_W-1:0] TEMP_OFFSET   = 25'd59392;

    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_CURRENT,
        KIND_TEMP,
        KIND_FLAG
    } t_field_kind;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        len;
        t_field_kind       kind;
    } t_field_desc;

    function automatic t_field_desc field_desc(input logic [FIELD_ID_W-1:0] id);
        t_field_desc d;
        unique case (id)
            5'd0:    d = '{addr: 6'd25, len: 2'd1, kind: KIND_PLAIN};
            5'd1:    d = '{addr: 6'd51, len: 2'd2, kind: KIND_PLAIN};
            5'd2:    d = '{addr: 6'd53, len: 2'd2, kind: KIND_PLAIN};
            5'd3:    d = '{addr: 6'd55, len: 2'd2, kind: KIND_PLAIN};
            5'd4:    d = '{addr: 6'd40, len: 2'd1, kind: KIND_PLAIN};
            5'd5:    d = '{addr: 6'd0,  len: 2'd3, kind: KIND_PLAIN};
            5'd6:    d = '{addr: 6'd9,  len: 2'd3, kind: KIND_CURRENT};
            5'd7:    d = '{addr: 6'd3,  len: 2'd3, kind: KIND_CURRENT};
            5'd8:    d = '{addr: 6'd6,  len: 2'd3, kind: KIND_CURRENT};
            5'd9:    d = '{addr: 6'd49, len: 2'd2, kind: KIND_PLAIN};
            5'd10:   d = '{addr: 6'd34, len: 2'd3, kind: KIND_PLAIN};
            5'd11:   d = '{addr: 6'd12, len: 2'd2, kind: KIND_PLAIN};
            5'd12:   d = '{addr: 6'd14, len: 2'd1, kind: KIND_PLAIN};
            5'd13:   d = '{addr: 6'd15, len: 2'd2, kind: KIND_PLAIN};
            5'd14:   d = '{addr: 6'd17, len: 2'd1, kind: KIND_PLAIN};
            5'd15:   d = '{addr: 6'd18, len: 2'd2, kind: KIND_TEMP};
            5'd16:   d = '{addr: 6'd20, len: 2'd1, kind: KIND_PLAIN};
            5'd17:   d = '{addr: 6'd21, len: 2'd2, kind: KIND_TEMP};
            5'd18:   d = '{addr: 6'd23, len: 2'd1, kind: KIND_PLAIN};
            5'd19:   d = '{addr: 6'd30, len: 2'd1, kind: KIND_FLAG};
            default: d = '{addr: 6'd0,  len: 2'd1, kind: KIND_PLAIN};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bms_status_frame_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Status frame decoder for a battery monitor link.
// Input channel: i_valid / o_stall with i_rx_byte, one frame byte per request.
// Bytes 0..56 are stored and summed; byte 57 is the 8-bit checksum.
// Output channel: o_valid / i_stall with o_field_id, o_field_value,
// o_frame_status and o_last_item.
// Bytes are taken one per cycle while the decoder is idle. After the
// checksum byte, a mismatch gives one request (status 1, last 1) once the
// output register is free. A match gives 20 field requests: each stored
// byte of a field is read (single read port of the frame memory) and then
// accumulated, then a post step and an emit follow; each temperature field
// adds the reciprocal divide by 1000. o_stall is high while a decode runs.
// A finished result waits in the output register while the next one is
// built; with i_stall high the sequencer holds until that register frees.
// Reset clears the byte counter, checksum and sequencer; frame memory
// content is not cleared and needs none, since every read byte is written
// earlier in the same frame.
module bms_status_frame_decoder_top (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [7:0]                            i_rx_byte,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic [bsfd_pkg::FIELD_ID_W-1:0]             o_field_id,
    output logic signed [bsfd_pkg::VALUE_W-1:0]         o_field_value,
    output logic                                       o_frame_status,
    output logic                                       o_last_item
);
    import bsfd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BAD  = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [7:0] mem [FRAME_LEN];

    logic [2:0]            r_state, n_state;
    logic [ADDR_W-1:0]     r_pos, n_pos;
    logic [7:0]            r_sum, n_sum;
    logic [FIELD_ID_W-1:0] r_fid, n_fid;
    logic [1:0]            r_cnt, n_cnt;
    logic [23:0]           r_acc, n_acc;
    logic [VALUE_W-1:0]    r_val, n_val;
    logic [23:0]           r_p_hi, n_p_hi;
    logic [7:0]            r_rd_data;

    logic                  r_ovalid, n_ovalid;
    logic [FIELD_ID_W-1:0] r_oid, n_oid;
    logic [VALUE_W-1:0]    r_oval, n_oval;
    logic                  r_ostat, n_ostat;
    logic                  r_olast, n_olast;

    t_field_desc        desc;
    logic [ADDR_W-1:0]  rd_addr;
    logic               in_acc;
    logic               wr_en;
    logic               out_free;
    logic               div_start;
    logic [VALUE_W-1:0] div_num;
    logic               div_done;
    logic [VALUE_W-1:0] div_quot;
    logic [15:0]        raw16;

    assign desc     = field_desc(r_fid);
    assign rd_addr  = desc.addr + {4'b0, r_cnt};
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign wr_en    = in_acc && (r_pos != SUM_POS);
    assign out_free = !r_ovalid || !i_stall;
    assign raw16    = r_acc[15:0];
    assign div_num  = {9'b0, raw16} * TEMP_MUL_FRAC + TEMP_ROUND;

    bsfd_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_pos] <= i_rx_byte;
        end
        if (r_state == S_READ) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_fid     = r_fid;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_val     = r_val;
        n_p_hi    = r_p_hi;
        div_start = 1'b0;
        n_ovalid  = r_ovalid && i_stall;
        n_oid     = r_oid;
        n_oval    = r_oval;
        n_ostat   = r_ostat;
        n_olast   = r_olast;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_pos != SUM_POS) begin
                        n_pos = r_pos + 6'd1;
                        n_sum = r_sum + i_rx_byte;
                    end else begin
                        n_pos = '0;
                        n_sum = '0;
                        n_fid = '0;
                        n_cnt = '0;
                        n_acc = '0;
                        n_state = (r_sum != i_rx_byte) ? S_BAD : S_READ;
                    end
                end
            end
            S_BAD: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oid    = '0;
                    n_oval   = '0;
                    n_ostat  = 1'b1;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_acc = {r_acc[15:0], r_rd_data};
                if (r_cnt == desc.len - 2'd1) begin
                    n_state = S_POST;
                end else begin
                    n_cnt   = r_cnt + 2'd1;
                    n_state = S_READ;
                end
            end
            S_POST: begin
                n_state = S_EMIT;
                unique case (desc.kind)
                    KIND_PLAIN: n_val = {1'b0, r_acc};
                    KIND_FLAG:  n_val = {18'b0, r_acc[6:0] & FLAG_MASK};
                    KIND_CURRENT: begin
                        // prefix byte selects zero, negative or positive magnitude
                        if (r_acc[23:16] == PREFIX_ZERO) begin
                            n_val = '0;
                        end else if (r_acc[23:16] == PREFIX_NEG) begin
                            n_val = '0 - {9'b0, raw16};
                        end else begin
                            n_val = {9'b0, raw16};
                        end
                    end
                    KIND_TEMP: begin
                        n_p_hi    = {8'b0, raw16} * TEMP_MUL_INT;
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                    default: n_val = {1'b0, r_acc};
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_val   = {1'b0, r_p_hi} + div_quot - TEMP_OFFSET;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oid    = r_fid;
                    n_oval   = r_val;
                    n_ostat  = 1'b0;
                    n_olast  = (r_fid == LAST_FIELD);
                    if (r_fid == LAST_FIELD) begin
                        n_state = S_IDLE;
                    end else begin
                        n_fid   = r_fid + 5'd1;
                        n_cnt   = '0;
                        n_acc   = '0;
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fid   <= n_fid;
        r_cnt   <= n_cnt;
        r_acc   <= n_acc;
        r_val   <= n_val;
        r_p_hi  <= n_p_hi;
        r_oid   <= n_oid;
        r_oval  <= n_oval;
        r_ostat <= n_ostat;
        r_olast <= n_olast;
    end

    assign o_valid        = r_ovalid;
    assign o_field_id     = r_oid;
    assign o_field_value  = r_oval;
    assign o_frame_status = r_ostat;
    assign o_last_item    = r_olast;

    a_bad_frame_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_status) |-> (o_last_item && o_field_id == '0 && o_field_value == '0))
        else $error("bad checksum result malformed");

    a_last_on_final_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_status) |-> (o_last_item == (o_field_id == LAST_FIELD)))
        else $error("last_item not on final field");

    a_checksum_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_pos == SUM_POS) |=> (r_pos == '0 && r_sum == '0 && r_state != S_IDLE))
        else $error("frame counter did not restart after checksum byte");

    a_div_only_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_FIN) |-> (desc.kind == KIND_TEMP))
        else $error("divider used on non-temperature field");

endmodule

`default_nettype wire

// ===== hdl/bsfd_div_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Divide by TEMP_DIV with a reciprocal multiply. The dividend is loaded on
// i_start and multiplied in the next cycle; o_done pulses the cycle after.
// ceil(2^35 / 1000) gives the exact floor for any dividend below 2^25.
module bsfd_div_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [bsfd_pkg::VALUE_W-1:0] i_num,
    output logic                             o_done,
    output logic [bsfd_pkg::VALUE_W-1:0]      o_quot
);
    import bsfd_pkg::*;

    localparam logic [25:0] RECIP = 26'd34359739;

    logic               r_busy;
    logic               r_done;
    logic [VALUE_W-1:0] r_num;
    logic [50:0]        r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
        end
        if (r_busy) begin
            r_prod <= {26'b0, r_num} * {25'b0, RECIP};
        end
    end

    // quotient is the product shifted down by 35
    assign o_done = r_done;
    assign o_quot = {9'b0, r_prod[50:35]};

endmodule

`default_nettype wire
